### src/lct_pkg.sv
// shared types, codes and the 4b5b table for the line code transmitter
package lct_pkg;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned WORD_W = 10;
  localparam int unsigned QDEPTH = 2;

  localparam logic [MODE_W-1:0] LOGIC_PLAIN = 2'd0;
  localparam logic [MODE_W-1:0] LOGIC_4B5B  = 2'd1;
  localparam logic [MODE_W-1:0] LOGIC_SCR   = 2'd2;

  localparam logic [MODE_W-1:0] LINE_NRZ = 2'd0;
  localparam logic [MODE_W-1:0] LINE_RZ  = 2'd1;
  localparam logic [MODE_W-1:0] LINE_AMI = 2'd2;
  localparam logic [MODE_W-1:0] LINE_MAN = 2'd3;

  localparam logic CFG_LOGIC_MODE = 1'b0;
  localparam logic CFG_LINE_MODE  = 1'b1;

  localparam logic signed [1:0] LVL_POS  = 2'sb01;
  localparam logic signed [1:0] LVL_ZERO = 2'sb00;
  localparam logic signed [1:0] LVL_NEG  = 2'sb11;

  // coded bits left aligned, first bit on the line at bit WORD_W-1
  typedef struct packed {
    logic [WORD_W-1:0] bits;
    logic              ten;
    logic              first;
  } item_t;

  function automatic logic [4:0] enc45(input logic [3:0] nib);
    logic [4:0] c;
    case (nib)
      4'h0: c = 5'h1E;
      4'h1: c = 5'h09;
      4'h2: c = 5'h14;
      4'h3: c = 5'h15;
      4'h4: c = 5'h0A;
      4'h5: c = 5'h0B;
      4'h6: c = 5'h0E;
      4'h7: c = 5'h0F;
      4'h8: c = 5'h12;
      4'h9: c = 5'h13;
      4'hA: c = 5'h16;
      4'hB: c = 5'h17;
      4'hC: c = 5'h1A;
      4'hD: c = 5'h1B;
      4'hE: c = 5'h1C;
      default: c = 5'h1D;
    endcase
    return c;
  endfunction

endpackage

### src/lct_front.sv
// front end: accepts bytes, applies the logical code and keeps scrambler history
module lct_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lct_pkg::MODE_W-1:0]  logic_mode,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_first_byte,
  input  logic                        q_full,
  output logic                        q_push,
  output lct_pkg::item_t              q_item
);

  logic [4:0] hist_r;
  logic [4:0] hist_nxt;
  logic [4:0] h;
  logic [7:0] scr;
  logic       b;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    h = in_first_byte ? 5'd0 : hist_r;
    scr = 8'd0;
    for (int k = 7; k >= 0; k--) begin
      b = in_data_byte[k] ^ h[2] ^ h[4];
      h = {h[3:0], b};
      scr[k] = b;
    end

    q_item.first = in_first_byte;
    case (logic_mode)
      lct_pkg::LOGIC_4B5B: begin
        q_item.bits = {lct_pkg::enc45(in_data_byte[7:4]), lct_pkg::enc45(in_data_byte[3:0])};
        q_item.ten  = 1'b1;
      end
      lct_pkg::LOGIC_SCR: begin
        q_item.bits = {scr, 2'b00};
        q_item.ten  = 1'b0;
      end
      default: begin
        q_item.bits = {in_data_byte, 2'b00};
        q_item.ten  = 1'b0;
      end
    endcase

    hist_nxt = hist_r;
    if (q_push) begin
      if (logic_mode == lct_pkg::LOGIC_SCR) begin
        hist_nxt = h;
      end else if (in_first_byte) begin
        hist_nxt = 5'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= 5'd0;
    end else begin
      hist_r <= hist_nxt;
    end
  end

endmodule

### src/lct_queue.sv
// two-entry queue between front and back
module lct_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lct_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output lct_pkg::item_t q_item
);

  lct_pkg::item_t ent_r [lct_pkg::QDEPTH];
  logic           wr_ptr_r;
  logic           wr_ptr_nxt;
  logic           rd_ptr_r;
  logic           rd_ptr_nxt;
  logic [1:0]     cnt_r;
  logic [1:0]     cnt_nxt;

  assign full    = (cnt_r == 2'(lct_pkg::QDEPTH));
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### src/lct_back.sv
// back end: serializes coded bits and maps them to line levels
module lct_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lct_pkg::MODE_W-1:0]  line_mode,
  input  logic                        q_valid,
  input  lct_pkg::item_t              q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_coded_bit,
  output logic signed [1:0]           out_level_first,
  output logic signed [1:0]           out_level_second,
  output logic                        out_last_of_byte
);

  logic [lct_pkg::WORD_W-1:0] sh_r;
  logic [lct_pkg::WORD_W-1:0] sh_nxt;
  logic [3:0]                 rem_r;
  logic [3:0]                 rem_nxt;
  logic                       cur_valid_r;
  logic                       cur_valid_nxt;
  logic                       first_pend_r;
  logic                       first_pend_nxt;
  logic                       ami_r;
  logic                       ami_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic                       bit_r;
  logic signed [1:0]          lv1_r;
  logic signed [1:0]          lv2_r;
  logic                       last_r;
  logic                       emit;
  logic                       last;
  logic                       b;
  logic                       pol;
  logic signed [1:0]          lv1;
  logic signed [1:0]          lv2;

  assign out_valid        = out_valid_r;
  assign out_coded_bit    = bit_r;
  assign out_level_first  = lv1_r;
  assign out_level_second = lv2_r;
  assign out_last_of_byte = last_r;

  always_comb begin
    emit  = cur_valid_r && (!out_valid_r || !out_stall);
    last  = (rem_r == 4'd1);
    q_pop = q_valid && (!cur_valid_r || (emit && last));
    b     = sh_r[lct_pkg::WORD_W-1];
    pol   = first_pend_r ? 1'b1 : ami_r;

    lv1 = lct_pkg::LVL_ZERO;
    lv2 = lct_pkg::LVL_ZERO;
    case (line_mode)
      lct_pkg::LINE_NRZ: begin
        lv1 = b ? lct_pkg::LVL_POS : lct_pkg::LVL_NEG;
        lv2 = lv1;
      end
      lct_pkg::LINE_RZ: begin
        lv1 = b ? lct_pkg::LVL_POS : lct_pkg::LVL_NEG;
        lv2 = lct_pkg::LVL_ZERO;
      end
      lct_pkg::LINE_AMI: begin
        if (b) begin
          lv1 = pol ? lct_pkg::LVL_POS : lct_pkg::LVL_NEG;
          lv2 = lv1;
        end
      end
      default: begin
        lv1 = b ? lct_pkg::LVL_POS : lct_pkg::LVL_NEG;
        lv2 = b ? lct_pkg::LVL_NEG : lct_pkg::LVL_POS;
      end
    endcase

    sh_nxt         = sh_r;
    rem_nxt        = rem_r;
    cur_valid_nxt  = cur_valid_r;
    first_pend_nxt = first_pend_r;
    ami_nxt        = ami_r;
    if (emit) begin
      sh_nxt         = {sh_r[lct_pkg::WORD_W-2:0], 1'b0};
      rem_nxt        = rem_r - 4'd1;
      first_pend_nxt = 1'b0;
      ami_nxt        = (line_mode == lct_pkg::LINE_AMI && b) ? ~pol : pol;
      if (last) begin
        cur_valid_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      sh_nxt         = q_item.bits;
      rem_nxt        = q_item.ten ? 4'd10 : 4'd8;
      cur_valid_nxt  = 1'b1;
      first_pend_nxt = q_item.first;
    end

    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      bit_r  <= b;
      lv1_r  <= lv1;
      lv2_r  <= lv2;
      last_r <= last;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r  <= 1'b0;
      first_pend_r <= 1'b0;
      ami_r        <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      cur_valid_r  <= cur_valid_nxt;
      first_pend_r <= first_pend_nxt;
      ami_r        <= ami_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule

### src/line_code_transmitter.sv
// line code transmitter top level: config registers, front, queue and back
// Takes one message byte per item and sends it MSB first as 8 coded bits
// (plain or scrambled) or 10 coded bits (4B5B), one result item per coded bit
// carrying the bit and its two half-bit line levels. The back-end serializer
// sets the rate: one coded bit per cycle unless out_stall holds it, and a
// steady stream runs with no gap between bytes. The front end takes a byte
// into a two-entry queue, so up to two bytes can wait while the current one
// is being sent. Write logic_mode and line_mode only
// while the block is idle.
module line_code_transmitter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [1:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              in_first_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_coded_bit,
  output logic signed [1:0] out_level_first,
  output logic signed [1:0] out_level_second,
  output logic              out_last_of_byte
);

  logic [lct_pkg::MODE_W-1:0] logic_mode_r;
  logic [lct_pkg::MODE_W-1:0] logic_mode_nxt;
  logic [lct_pkg::MODE_W-1:0] line_mode_r;
  logic [lct_pkg::MODE_W-1:0] line_mode_nxt;
  logic                       q_full;
  logic                       q_push;
  lct_pkg::item_t             push_item;
  logic                       q_pop;
  logic                       q_valid;
  lct_pkg::item_t             head_item;

  always_comb begin
    logic_mode_nxt = logic_mode_r;
    line_mode_nxt  = line_mode_r;
    if (cfg_we) begin
      case (cfg_index)
        lct_pkg::CFG_LOGIC_MODE: logic_mode_nxt = cfg_wdata;
        lct_pkg::CFG_LINE_MODE:  line_mode_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      logic_mode_r <= lct_pkg::LOGIC_PLAIN;
      line_mode_r  <= lct_pkg::LINE_NRZ;
    end else begin
      logic_mode_r <= logic_mode_nxt;
      line_mode_r  <= line_mode_nxt;
    end
  end

  lct_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .logic_mode    (logic_mode_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  lct_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (head_item)
  );

  lct_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .line_mode        (line_mode_r),
    .q_valid          (q_valid),
    .q_item           (head_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_coded_bit    (out_coded_bit),
    .out_level_first  (out_level_first),
    .out_level_second (out_level_second),
    .out_last_of_byte (out_last_of_byte)
  );

endmodule

### src/lct_checker.sv
// port-level checks for the line code transmitter, bound to the top level
module lct_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_coded_bit,
  input logic signed [1:0] out_level_first,
  input logic signed [1:0] out_level_second,
  input logic              out_last_of_byte
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_coded_bit) && $stable(out_level_first)
      && $stable(out_level_second) && $stable(out_last_of_byte))
    else $error("stalled result item changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level_first != 2'sb10 && out_level_second != 2'sb10)
    else $error("line level out of range");

  a_half_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_level_first == 2'sb00 |-> out_level_second == 2'sb00)
    else $error("zero first half with nonzero second half");

endmodule

bind line_code_transmitter lct_checker u_lct_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_coded_bit    (out_coded_bit),
  .out_level_first  (out_level_first),
  .out_level_second (out_level_second),
  .out_last_of_byte (out_last_of_byte)
);

### tb/sv/tb_line_code_transmitter.sv
// self-checking testbench for the line code transmitter: byte stimulus, bit-level scoreboard
`timescale 1ns / 100ps

class line_code_scoreboard;
  typedef struct packed {
    logic              coded;
    logic signed [1:0] lv_a;
    logic signed [1:0] lv_b;
    logic              last;
  } line_bit_t;

  line_bit_t   expected_bits[$];
  logic [1:0]  logic_mode = lct_pkg::LOGIC_PLAIN;
  logic [1:0]  line_mode = lct_pkg::LINE_NRZ;
  logic [4:0]  scramble_hist = '0;
  logic        ami_positive = 1'b1;
  int unsigned errors = 0;
  int unsigned bytes_in = 0;
  int unsigned bits_seen = 0;

  function void set_modes(input logic [1:0] lm, input logic [1:0] ln);
    logic_mode = lm;
    line_mode = ln;
  endfunction

  function int unsigned pending_count();
    return expected_bits.size();
  endfunction

  function logic [4:0] nibble_code(input logic [3:0] nib);
    logic [79:0] codes;
    codes = {5'h1E, 5'h09, 5'h14, 5'h15, 5'h0A, 5'h0B, 5'h0E, 5'h0F,
             5'h12, 5'h13, 5'h16, 5'h17, 5'h1A, 5'h1B, 5'h1C, 5'h1D};
    return codes[79 - 5 * int'(nib) -: 5];
  endfunction

  function void push_bit(input logic b, input logic last);
    line_bit_t e;
    e.coded = b;
    e.last = last;
    case (line_mode)
      lct_pkg::LINE_NRZ: begin
        e.lv_a = b ? lct_pkg::LVL_POS : lct_pkg::LVL_NEG;
        e.lv_b = e.lv_a;
      end
      lct_pkg::LINE_RZ: begin
        e.lv_a = b ? lct_pkg::LVL_POS : lct_pkg::LVL_NEG;
        e.lv_b = lct_pkg::LVL_ZERO;
      end
      lct_pkg::LINE_AMI: begin
        if (b) begin
          e.lv_a = ami_positive ? lct_pkg::LVL_POS : lct_pkg::LVL_NEG;
          ami_positive = ~ami_positive;
        end else begin
          e.lv_a = lct_pkg::LVL_ZERO;
        end
        e.lv_b = e.lv_a;
      end
      default: begin
        e.lv_a = b ? lct_pkg::LVL_POS : lct_pkg::LVL_NEG;
        e.lv_b = b ? lct_pkg::LVL_NEG : lct_pkg::LVL_POS;
      end
    endcase
    expected_bits.push_back(e);
  endfunction

  function void note_byte(input logic [7:0] d, input logic first);
    logic [9:0] word;
    int         n;
    logic       b;
    word = '0;
    if (first) begin
      scramble_hist = '0;
      ami_positive = 1'b1;
    end
    case (logic_mode)
      lct_pkg::LOGIC_4B5B: begin
        word = {nibble_code(d[7:4]), nibble_code(d[3:0])};
        n = 10;
      end
      lct_pkg::LOGIC_SCR: begin
        for (int k = 7; k >= 0; k--) begin
          b = d[k] ^ scramble_hist[2] ^ scramble_hist[4];
          scramble_hist = {scramble_hist[3:0], b};
          word[k] = b;
        end
        n = 8;
      end
      default: begin
        word = {2'b00, d};
        n = 8;
      end
    endcase
    for (int k = n - 1; k >= 0; k--)
      push_bit(word[k], k == 0);
    bytes_in++;
  endfunction

  task report(input string msg);
    errors++;
    if (errors <= 40)
      $display("ERROR: %s", msg);
  endtask

  task check_bit(input logic coded, input logic signed [1:0] la, input logic signed [1:0] lb,
                 input logic last);
    line_bit_t e;
    bits_seen++;
    if (expected_bits.size() == 0) begin
      report($sformatf("bit %0d arrived with nothing expected (coded=%0b)", bits_seen, coded));
      return;
    end
    e = expected_bits.pop_front();
    if (coded !== e.coded || la !== e.lv_a || lb !== e.lv_b || last !== e.last)
      report($sformatf("bit %0d: got coded=%0b levels=%0d,%0d last=%0b, want %0b %0d,%0d %0b",
                       bits_seen, coded, la, lb, last, e.coded, e.lv_a, e.lv_b, e.last));
  endtask
endclass

module tb_line_code_transmitter;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned RANDOM_BYTES = 180;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam logic [lct_pkg::MODE_W-1:0] LOGIC_UNUSED = 2'd3;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic              cfg_index;
  logic [1:0]        cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_data_byte;
  logic              in_first_byte;
  logic              out_valid;
  logic              out_stall;
  logic              out_coded_bit;
  logic signed [1:0] out_level_first;
  logic signed [1:0] out_level_second;
  logic              out_last_of_byte;

  line_code_scoreboard sb = new();
  int unsigned         cycles = 0;
  int unsigned         mode_changes = 0;
  logic [1:0]          cur_logic;
  logic [1:0]          cur_line;
  logic                modes_set = 1'b0;

  line_code_transmitter uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_first_byte    (in_first_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_coded_bit    (out_coded_bit),
    .out_level_first  (out_level_first),
    .out_level_second (out_level_second),
    .out_last_of_byte (out_last_of_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 50);
  endfunction

  // receiver back-pressure
  initial begin
    int unsigned n;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 5))
        @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_bit(out_coded_bit, out_level_first, out_level_second, out_last_of_byte);
  end

  task automatic wait_drained(input int unsigned settle);
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_modes(input logic [1:0] lm, input logic [1:0] ln);
    cfg_we    <= 1'b1;
    cfg_index <= lct_pkg::CFG_LOGIC_MODE;
    cfg_wdata <= lm;
    @(posedge clk);
    cfg_index <= lct_pkg::CFG_LINE_MODE;
    cfg_wdata <= ln;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_modes(lm, ln);
    cur_logic = lm;
    cur_line = ln;
    modes_set = 1'b1;
    mode_changes++;
  endtask

  // sends one byte under the given modes, reconfiguring once idle if they differ
  task automatic send_byte(input logic [1:0] lm, input logic [1:0] ln, input logic [7:0] d,
                           input logic f, input int unsigned gap);
    if (!modes_set || lm != cur_logic || ln != cur_line) begin
      in_valid <= 1'b0;
      wait_drained(SETTLE_CYCLES);
      write_modes(lm, ln);
    end else if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= d;
    in_first_byte <= f;
    do @(posedge clk); while (in_stall);
    sb.note_byte(d, f);
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase_len;
    int unsigned msg_left;
    logic        calm;
    logic [1:0]  lm;
    logic [1:0]  ln;
    logic        f;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = lct_pkg::CFG_LOGIC_MODE;
    cfg_wdata     = lct_pkg::LOGIC_PLAIN;
    in_valid      = 1'b0;
    in_data_byte  = 8'h00;
    in_first_byte = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(lct_pkg::LOGIC_PLAIN, lct_pkg::LINE_NRZ, 8'h00, 1'b1, pick_gap());
    send_byte(lct_pkg::LOGIC_PLAIN, lct_pkg::LINE_NRZ, 8'hFF, 1'b0, pick_gap());
    send_byte(lct_pkg::LOGIC_PLAIN, lct_pkg::LINE_RZ, 8'h5A, 1'b0, pick_gap());
    // all sixteen nibble codes
    send_byte(lct_pkg::LOGIC_4B5B, lct_pkg::LINE_MAN, 8'h01, 1'b1, pick_gap());
    send_byte(lct_pkg::LOGIC_4B5B, lct_pkg::LINE_MAN, 8'h23, 1'b0, pick_gap());
    send_byte(lct_pkg::LOGIC_4B5B, lct_pkg::LINE_MAN, 8'h45, 1'b0, pick_gap());
    send_byte(lct_pkg::LOGIC_4B5B, lct_pkg::LINE_MAN, 8'h67, 1'b0, pick_gap());
    send_byte(lct_pkg::LOGIC_4B5B, lct_pkg::LINE_AMI, 8'h89, 1'b0, pick_gap());
    send_byte(lct_pkg::LOGIC_4B5B, lct_pkg::LINE_AMI, 8'hAB, 1'b0, pick_gap());
    send_byte(lct_pkg::LOGIC_4B5B, lct_pkg::LINE_AMI, 8'hCD, 1'b0, pick_gap());
    send_byte(lct_pkg::LOGIC_4B5B, lct_pkg::LINE_AMI, 8'hEF, 1'b0, pick_gap());
    send_byte(lct_pkg::LOGIC_SCR, lct_pkg::LINE_AMI, 8'hFF, 1'b1, pick_gap());
    send_byte(lct_pkg::LOGIC_SCR, lct_pkg::LINE_AMI, 8'h00, 1'b0, pick_gap());
    send_byte(lct_pkg::LOGIC_SCR, lct_pkg::LINE_AMI, 8'h80, 1'b0, pick_gap());
    // history holds in the unused mode, polarity carries on
    send_byte(LOGIC_UNUSED, lct_pkg::LINE_AMI, 8'hA5, 1'b0, pick_gap());
    send_byte(lct_pkg::LOGIC_SCR, lct_pkg::LINE_NRZ, 8'h3C, 1'b0, pick_gap());
    send_byte(lct_pkg::LOGIC_SCR, lct_pkg::LINE_RZ, 8'hC3, 1'b1, pick_gap());
    send_byte(LOGIC_UNUSED, lct_pkg::LINE_MAN, 8'h7E, 1'b1, pick_gap());
    send_byte(LOGIC_UNUSED, lct_pkg::LINE_MAN, 8'h81, 1'b0, pick_gap());

    // random phases of messages, each phase under one mode setting
    sent = 0;
    msg_left = 0;
    while (sent < RANDOM_BYTES) begin
      lm = 2'($urandom_range(0, 3));
      ln = 2'($urandom_range(0, 3));
      phase_len = $urandom_range(4, 24);
      calm = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        if (msg_left == 0) begin
          f = 1'b1;
          msg_left = $urandom_range(1, 8);
        end else begin
          f = 1'b0;
        end
        if ($urandom_range(0, 9) == 0)
          f = 1'($urandom_range(0, 1));
        msg_left--;
        send_byte(lm, ln, 8'($urandom_range(0, 255)), f, calm ? 0 : pick_gap());
        sent++;
      end
    end
    in_valid <= 1'b0;

    wait_drained(TAIL_CYCLES);
    if (sb.pending_count() != 0)
      sb.report($sformatf("%0d coded bits never arrived", sb.pending_count()));

    $display("sent %0d bytes under %0d mode settings, checked %0d coded bits",
             sb.bytes_in, mode_changes, sb.bits_seen);
    $display("mismatches: %0d", sb.errors);
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
